[src/tllc_pkg.sv]
// Shared types, character codes and helpers for the line/column token lexer.
package tllc_pkg;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  // Token kinds as they appear on the result word.
  typedef enum logic [2:0] {
    KIND_COMMENT = 3'd0,
    KIND_LBRACE  = 3'd1,
    KIND_RBRACE  = 3'd2,
    KIND_ARROW   = 3'd3,
    KIND_IDENT   = 3'd4,
    KIND_NEWLINE = 3'd5,
    KIND_END     = 3'd6
  } token_kind_e;

  // Scanner state, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_COMMENT = 3'b010,
    MODE_IDENT   = 3'b100
  } scan_mode_e;

  // True for every byte that ends an identifier.
  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE) ||
           (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LESS) ||
           (b == CH_GREATER) || (b == CH_MINUS) || (b == CH_HASH);
  endfunction

endpackage

[src/token_lexer_line_col_top.sv]
// Streaming lexer: one source byte per word in, tokens with line, column, offset and length out.
// A token is written to the result queue when the byte that completes it is accepted.
// Throughput: one input word per cycle; a word that yields two tokens enqueues both, and they leave in order.
// The input stalls only while the four-entry result queue holds more than two tokens.
// Reset (asynchronous, active low) empties the queue and returns to line 1, offset 0, idle.
// An end-of-input word flushes the open token, emits the end token and returns to that state.
module token_lexer_line_col_top #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             byte_value_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             token_kind_o,
  output logic [COUNT_BITS-1:0]  line_number_o,
  output logic [COUNT_BITS-1:0]  column_number_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [COUNT_BITS-1:0]  token_length_o,
  output logic                   last_of_run_o
);

  localparam int unsigned WIDE_BITS =
    ((OFFSET_BITS > COUNT_BITS) ? OFFSET_BITS : COUNT_BITS) + 1;

  // Column of a token start: distance from the line start plus one, saturating.
  function automatic logic [COUNT_BITS-1:0] calc_col(input logic [OFFSET_BITS-1:0] start,
                                                      input logic [OFFSET_BITS-1:0] lbo);
    logic [OFFSET_BITS-1:0] diff;
    logic [WIDE_BITS-1:0]   diff_w;
    logic [WIDE_BITS-1:0]   max_w;
    diff   = (start >= lbo) ? (start - lbo) : '0;
    diff_w = WIDE_BITS'(diff);
    max_w  = WIDE_BITS'({COUNT_BITS{1'b1}});
    if (diff_w >= max_w) begin
      return {COUNT_BITS{1'b1}};
    end
    return COUNT_BITS'(diff_w + WIDE_BITS'(1));
  endfunction

  // Scanner state.
  tllc_pkg::scan_mode_e   mode_q, mode_d;
  logic [COUNT_BITS-1:0]  line_q, line_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] lbo_q, lbo_d;
  logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
  logic [COUNT_BITS-1:0]  plen_q, plen_d;

  // Result queue.
  tllc_pkg::token_kind_e  fq_kind_q  [tllc_pkg::FIFO_DEPTH];
  logic [COUNT_BITS-1:0]  fq_line_q  [tllc_pkg::FIFO_DEPTH];
  logic [COUNT_BITS-1:0]  fq_col_q   [tllc_pkg::FIFO_DEPTH];
  logic [OFFSET_BITS-1:0] fq_start_q [tllc_pkg::FIFO_DEPTH];
  logic [COUNT_BITS-1:0]  fq_len_q   [tllc_pkg::FIFO_DEPTH];
  logic                   fq_last_q  [tllc_pkg::FIFO_DEPTH];
  logic [tllc_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tllc_pkg::FIFO_CW-1:0] cnt_q;

  logic in_accept, out_accept;

  // Flushed pending token and single-byte (or end) token of this word.
  logic                   pf_valid, sb_valid;
  tllc_pkg::token_kind_e  pf_kind, sb_kind;
  logic [OFFSET_BITS-1:0] sb_start;
  logic [COUNT_BITS-1:0]  sb_len;

  // Up to two tokens to enqueue, in order.
  logic                   s0_valid, s1_valid;
  tllc_pkg::token_kind_e  s0_kind;
  logic [OFFSET_BITS-1:0] s0_start;
  logic [COUNT_BITS-1:0]  s0_len;
  logic [COUNT_BITS-1:0]  s0_col, s1_col;
  logic [tllc_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic [tllc_pkg::FIFO_CW-1:0] n_push;

  assign in_stall_o = (cnt_q > tllc_pkg::FIFO_CW'(2));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_accept  = out_valid_o && !out_stall_i;

  // Classify the byte and work out the next scanner state.
  always_comb begin
    logic run_idle;
    logic flush;
    mode_d   = mode_q;
    line_d   = line_q;
    pos_d    = pos_q;
    lbo_d    = lbo_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    pf_valid = 1'b0;
    pf_kind  = tllc_pkg::KIND_IDENT;
    sb_valid = 1'b0;
    sb_kind  = tllc_pkg::KIND_END;
    sb_start = pos_q;
    sb_len   = COUNT_BITS'(1);
    run_idle = 1'b0;
    flush    = 1'b0;

    if (end_of_input_i) begin
      // Flush the open token, emit the end token, return to the reset state.
      pf_valid = (mode_q == tllc_pkg::MODE_COMMENT) || (mode_q == tllc_pkg::MODE_IDENT);
      pf_kind  = (mode_q == tllc_pkg::MODE_COMMENT) ? tllc_pkg::KIND_COMMENT
                                                    : tllc_pkg::KIND_IDENT;
      sb_valid = 1'b1;
      sb_kind  = tllc_pkg::KIND_END;
      sb_len   = '0;
      mode_d   = tllc_pkg::MODE_IDLE;
      line_d   = COUNT_BITS'(1);
      pos_d    = '0;
      lbo_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
    end else begin
      case (mode_q)
        tllc_pkg::MODE_COMMENT: begin
          flush   = (byte_value_i == tllc_pkg::CH_NEWLINE);
          pf_kind = tllc_pkg::KIND_COMMENT;
        end
        tllc_pkg::MODE_IDENT: begin
          flush   = tllc_pkg::is_delim(byte_value_i);
          pf_kind = tllc_pkg::KIND_IDENT;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase
      pf_valid = flush;
      run_idle = run_idle || flush;

      if (!run_idle) begin
        // Token continues.
        plen_d = (plen_q == {COUNT_BITS{1'b1}}) ? plen_q : plen_q + COUNT_BITS'(1);
      end else begin
        mode_d = tllc_pkg::MODE_IDLE;
        case (byte_value_i) inside
          tllc_pkg::CH_SPACE, tllc_pkg::CH_TAB: begin
          end
          tllc_pkg::CH_LBRACE: begin
            sb_valid = 1'b1;
            sb_kind  = tllc_pkg::KIND_LBRACE;
          end
          tllc_pkg::CH_RBRACE: begin
            sb_valid = 1'b1;
            sb_kind  = tllc_pkg::KIND_RBRACE;
          end
          tllc_pkg::CH_LESS, tllc_pkg::CH_GREATER, tllc_pkg::CH_MINUS: begin
            sb_valid = 1'b1;
            sb_kind  = tllc_pkg::KIND_ARROW;
          end
          tllc_pkg::CH_NEWLINE: begin
            sb_valid = 1'b1;
            sb_kind  = tllc_pkg::KIND_NEWLINE;
            line_d   = (line_q == {COUNT_BITS{1'b1}}) ? line_q : line_q + COUNT_BITS'(1);
            lbo_d    = (pos_q == {OFFSET_BITS{1'b1}}) ? pos_q : pos_q + OFFSET_BITS'(1);
          end
          default: begin
            // Open a comment or an identifier.
            mode_d   = (byte_value_i == tllc_pkg::CH_HASH) ? tllc_pkg::MODE_COMMENT
                                                           : tllc_pkg::MODE_IDENT;
            pstart_d = pos_q;
            plen_d   = COUNT_BITS'(1);
          end
        endcase
      end
      pos_d = (pos_q == {OFFSET_BITS{1'b1}}) ? pos_q : pos_q + OFFSET_BITS'(1);
    end
  end

  // Order the tokens of this word; the flushed one goes first.
  assign s0_valid  = pf_valid || sb_valid;
  assign s1_valid  = pf_valid && sb_valid;
  assign s0_kind   = pf_valid ? pf_kind : sb_kind;
  assign s0_start  = pf_valid ? pstart_q : sb_start;
  assign s0_len    = pf_valid ? plen_q : sb_len;
  assign s0_col    = calc_col(s0_start, lbo_q);
  assign s1_col    = calc_col(sb_start, lbo_q);
  assign wr_ptr_p1 = wr_ptr_q + tllc_pkg::FIFO_AW'(1);
  assign n_push    = in_accept ? (tllc_pkg::FIFO_CW'(s0_valid) + tllc_pkg::FIFO_CW'(s1_valid))
                               : '0;

  // Scanner state and queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= tllc_pkg::MODE_IDLE;
      line_q   <= COUNT_BITS'(1);
      pos_q    <= '0;
      lbo_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_accept) begin
        mode_q   <= mode_d;
        line_q   <= line_d;
        pos_q    <= pos_d;
        lbo_q    <= lbo_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
      end
      wr_ptr_q <= wr_ptr_q + tllc_pkg::FIFO_AW'(n_push);
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + tllc_pkg::FIFO_AW'(1);
      end
      cnt_q <= cnt_q + n_push - tllc_pkg::FIFO_CW'(out_accept);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (in_accept && s0_valid) begin
      fq_kind_q[wr_ptr_q]  <= s0_kind;
      fq_line_q[wr_ptr_q]  <= line_q;
      fq_col_q[wr_ptr_q]   <= s0_col;
      fq_start_q[wr_ptr_q] <= s0_start;
      fq_len_q[wr_ptr_q]   <= s0_len;
      fq_last_q[wr_ptr_q]  <= !s1_valid;
    end
    if (in_accept && s1_valid) begin
      fq_kind_q[wr_ptr_p1]  <= sb_kind;
      fq_line_q[wr_ptr_p1]  <= line_q;
      fq_col_q[wr_ptr_p1]   <= s1_col;
      fq_start_q[wr_ptr_p1] <= sb_start;
      fq_len_q[wr_ptr_p1]   <= sb_len;
      fq_last_q[wr_ptr_p1]  <= 1'b1;
    end
  end

  // Head of the queue drives the output word.
  assign token_kind_o    = fq_kind_q[rd_ptr_q];
  assign line_number_o   = fq_line_q[rd_ptr_q];
  assign column_number_o = fq_col_q[rd_ptr_q];
  assign start_offset_o  = fq_start_q[rd_ptr_q];
  assign token_length_o  = fq_len_q[rd_ptr_q];
  assign last_of_run_o   = fq_last_q[rd_ptr_q];

  // The queue never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tllc_pkg::FIFO_CW'(tllc_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // End of input returns the scanner to its reset state.
  a_eoi_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && end_of_input_i |=>
      pos_q == '0 && line_q == COUNT_BITS'(1) && mode_q == tllc_pkg::MODE_IDLE)
    else $error("scanner not cleared after end of input");

  // A word that yields a token makes a result visible next cycle.
  a_token_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && s0_valid |=> out_valid_o)
    else $error("token lost");

  // The line counter never reaches zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter is zero");

  // The line start never runs ahead of the byte position.
  a_lbo_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbo_q <= pos_q)
    else $error("line start beyond byte position");

endmodule
